// ----- sv/xfse_pkg.sv -----
`default_nettype none

package xfse_pkg;

  // Field widths of one beat on either side.
  localparam int SampleW  = 64;
  localparam int ByteW    = 8;

  // Code word: '11' + 5-bit leading + 6-bit length + 64 bits + 12-bit end marker.
  localparam int LeadW      = 5;
  localparam int LenFieldW  = 6;
  localparam int MarkerBits = 12;
  localparam int CodeW      = 2 + LeadW + LenFieldW + SampleW + MarkerBits;
  localparam int CntW       = 7;

  // Control prefixes of a nonzero XOR: reuse of the stored window, or a new one.
  localparam logic [1:0] CtlReuse = 2'b10;
  localparam logic [1:0] CtlNew   = 2'b11;

  // Bit accumulator: up to seven carried bits plus one full code word.
  localparam int AccW = CodeW + ByteW - 1;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // One coded sample, left aligned (first bit to send in the top bit).
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [CntW-1:0]  nbits;
    logic             last;
  } code_entry_t;

endpackage

`default_nettype wire

// ----- sv/xor_float_stream_encoder.sv -----
`default_nettype none

// Channel   Direction  Handshake                      Payload
// sample    in         sample_valid_i/sample_ready_o  sample_bits_i, end_of_series_i
// out       out        out_valid_o/out_ready_i        out_byte_o, last_of_run_o, stream_done_o
//
// The front end takes one sample beat per cycle while its stages are not stalled
// and runs it through three stages (XOR with the previous sample, per-byte zero
// counts, window decision and code assembly) into a small queue of coded words.
// The back end drains one coded word at a time and sends one byte per cycle while
// the output is ready; it takes no new word until it has sent every whole byte
// of the current one, so the byte-wide output port sets the sustained rate.
// Reset clears all series state; the next sample after reset or after an
// end-of-series beat is sent raw. Either side may stall without losing beats.

module xor_float_stream_encoder #(
  parameter int QueueDepth = xfse_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sample_valid_i,
  output logic                         sample_ready_o,
  input  logic [xfse_pkg::SampleW-1:0] sample_bits_i,
  input  logic                         end_of_series_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [xfse_pkg::ByteW-1:0]   out_byte_o,
  output logic                         last_of_run_o,
  output logic                         stream_done_o
);
  import xfse_pkg::*;

  // Coded words between the front end and the queue, and the queue and the
  // packer.
  code_entry_t fq_entry, qb_entry;
  logic        fq_valid, fq_ready;
  logic        qb_valid, qb_ready;

  // The front end owns the previous sample and the leading/trailing window,
  // so window decisions are made in sample order no matter how the output
  // stalls.
  xfse_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_valid_i  (sample_valid_i),
    .sample_ready_o  (sample_ready_o),
    .sample_bits_i   (sample_bits_i),
    .end_of_series_i (end_of_series_i),
    .entry_valid_o   (fq_valid),
    .entry_ready_i   (fq_ready),
    .entry_o         (fq_entry)
  );

  // The queue absorbs bursts of short codes while the packer works on a long one.
  xfse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_entry_i (fq_entry),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_entry_o (qb_entry)
  );

  // The packer keeps the partial byte between samples, appends each coded
  // word to it and hands out whole bytes through a registered output stage.
  xfse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (qb_valid),
    .entry_ready_o (qb_ready),
    .entry_i       (qb_entry),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .stream_done_o (stream_done_o)
  );

endmodule

`default_nettype wire

// ----- sv/xfse_front.sv -----
`default_nettype none

module xfse_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sample_valid_i,
  output logic                         sample_ready_o,
  input  logic [xfse_pkg::SampleW-1:0] sample_bits_i,
  input  logic                         end_of_series_i,
  output logic                         entry_valid_o,
  input  logic                         entry_ready_i,
  output xfse_pkg::code_entry_t        entry_o
);
  import xfse_pkg::*;

  typedef enum logic [3:0] {
    ModeRaw   = 4'b0001,
    ModeZero  = 4'b0010,
    ModeReuse = 4'b0100,
    ModeNew   = 4'b1000
  } mode_e;

  localparam int NumChunks = SampleW / ByteW;
  localparam int TrailW    = $clog2(SampleW);
  localparam int LenW      = $clog2(SampleW) + 1;
  localparam logic [LeadW-1:0] LeadMax = '1;
  localparam logic [CodeW-1:0] MarkerWord =
    {{MarkerBits{1'b1}}, {(CodeW-MarkerBits){1'b0}}};

  // Leading and trailing zero count of one nonzero byte.
  function automatic logic [2:0] lz8(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 3'(7 - i);
    end
    return n;
  endfunction

  function automatic logic [2:0] tz8(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) n = 3'(i);
    end
    return n;
  endfunction

  logic                is_first_q;
  logic [SampleW-1:0]  prev_q;

  logic                s1_v_q, s1_first_q, s1_last_q;
  logic [SampleW-1:0]  s1_x_q;

  logic                s2_v_q, s2_first_q, s2_last_q;
  logic [SampleW-1:0]  s2_x_q;
  logic [NumChunks-1:0] s2_nz_q;
  logic [2:0]          s2_lz_q [NumChunks];
  logic [2:0]          s2_tz_q [NumChunks];

  logic                s3_v_q, s3_last_q;
  logic [SampleW-1:0]  s3_x_q;
  mode_e               s3_mode_q;
  logic [LeadW-1:0]    s3_shamt_q, s3_lead_q;
  logic [LenW-1:0]     s3_len_q;

  logic                win_v_q;
  logic [LeadW-1:0]    win_lead_q;
  logic [TrailW-1:0]   win_trail_q;

  logic s1_go, s2_go, s3_go, in_acc;

  assign s3_go          = s3_v_q && entry_ready_i;
  assign s2_go          = s2_v_q && (!s3_v_q || s3_go);
  assign s1_go          = s1_v_q && (!s2_v_q || s2_go);
  assign sample_ready_o = !s1_v_q || s1_go;
  assign in_acc         = sample_valid_i && sample_ready_o;
  assign entry_valid_o  = s3_v_q;

  // Stage 3 decision: full counts, clamp and window check.
  logic [TrailW-1:0] lead_full, trail;
  logic [LeadW-1:0]  lead_c;
  logic [LenW-1:0]   len_new, len_reuse;
  logic              x_zero, reuse_ok;
  mode_e             mode_d;

  always_comb begin
    lead_full = '0;
    trail     = '0;
    for (int c = 0; c < NumChunks; c++) begin
      if (s2_nz_q[c]) lead_full = TrailW'((NumChunks - 1 - c) * ByteW) + TrailW'(s2_lz_q[c]);
    end
    for (int c = NumChunks - 1; c >= 0; c--) begin
      if (s2_nz_q[c]) trail = TrailW'(c * ByteW) + TrailW'(s2_tz_q[c]);
    end
    x_zero    = ~|s2_nz_q;
    lead_c    = (lead_full > TrailW'(LeadMax)) ? LeadMax : lead_full[LeadW-1:0];
    len_new   = LenW'(SampleW) - LenW'(lead_c) - LenW'(trail);
    len_reuse = LenW'(SampleW) - LenW'(win_lead_q) - LenW'(win_trail_q);
    reuse_ok  = win_v_q && (lead_c >= win_lead_q) && (trail >= win_trail_q);
    if (s2_first_q)    mode_d = ModeRaw;
    else if (x_zero)   mode_d = ModeZero;
    else if (reuse_ok) mode_d = ModeReuse;
    else               mode_d = ModeNew;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_first_q  <= 1'b1;
      prev_q      <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      win_v_q     <= 1'b0;
      win_lead_q  <= '0;
      win_trail_q <= '0;
    end else begin
      if (in_acc) begin
        if (end_of_series_i) begin
          is_first_q <= 1'b1;
          prev_q     <= '0;
        end else begin
          is_first_q <= 1'b0;
          prev_q     <= sample_bits_i;
        end
      end
      if (sample_ready_o)        s1_v_q <= sample_valid_i;
      if (!s2_v_q || s2_go)      s2_v_q <= s1_v_q;
      if (!s3_v_q || s3_go)      s3_v_q <= s2_v_q;
      if (s2_go) begin
        if (s2_last_q) begin
          win_v_q     <= 1'b0;
          win_lead_q  <= '0;
          win_trail_q <= '0;
        end else if (mode_d == ModeNew) begin
          win_v_q     <= 1'b1;
          win_lead_q  <= lead_c;
          win_trail_q <= trail;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_x_q     <= is_first_q ? sample_bits_i : (sample_bits_i ^ prev_q);
      s1_first_q <= is_first_q;
      s1_last_q  <= end_of_series_i;
    end
    if (s1_go) begin
      s2_x_q     <= s1_x_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      for (int c = 0; c < NumChunks; c++) begin
        s2_nz_q[c] <= |s1_x_q[c*ByteW +: ByteW];
        s2_lz_q[c] <= lz8(s1_x_q[c*ByteW +: ByteW]);
        s2_tz_q[c] <= tz8(s1_x_q[c*ByteW +: ByteW]);
      end
    end
    if (s2_go) begin
      s3_x_q     <= s2_x_q;
      s3_mode_q  <= mode_d;
      s3_shamt_q <= (mode_d == ModeReuse) ? win_lead_q : lead_c;
      s3_lead_q  <= lead_c;
      s3_len_q   <= (mode_d == ModeReuse) ? len_reuse : len_new;
      s3_last_q  <= s2_last_q;
    end
  end

  // Code word assembly. Shifting the XOR left by the leading count leaves
  // exactly the meaningful bits at the top, with zeros below them.
  logic [SampleW-1:0] bits;
  logic [CodeW-1:0]   code;
  logic [CntW-1:0]    nbits;

  always_comb begin
    bits = s3_x_q << s3_shamt_q;
    unique case (s3_mode_q)
      ModeRaw: begin
        code  = {s3_x_q, {(CodeW-SampleW){1'b0}}};
        nbits = CntW'(SampleW);
      end
      ModeZero: begin
        code  = '0;
        nbits = CntW'(1);
      end
      ModeReuse: begin
        code  = {CtlReuse, bits, {(CodeW-SampleW-2){1'b0}}};
        nbits = CntW'(2) + CntW'(s3_len_q);
      end
      ModeNew: begin
        code  = {CtlNew, s3_lead_q, s3_len_q[LenFieldW-1:0], bits, {MarkerBits{1'b0}}};
        nbits = CntW'(2 + LeadW + LenFieldW) + CntW'(s3_len_q);
      end
      default: begin
        code  = '0;
        nbits = '0;
      end
    endcase
    if (s3_last_q) begin
      code  = code | (MarkerWord >> nbits);
      nbits = nbits + CntW'(MarkerBits);
    end
    entry_o.code  = code;
    entry_o.nbits = nbits;
    entry_o.last  = s3_last_q;
  end

endmodule

`default_nettype wire

// ----- sv/xfse_queue.sv -----
`default_nettype none

module xfse_queue #(
  parameter int Depth = xfse_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  xfse_pkg::code_entry_t wr_entry_i,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output xfse_pkg::code_entry_t rd_entry_o
);
  import xfse_pkg::*;

  localparam int PtrW   = $clog2(Depth);
  localparam int CountW = $clog2(Depth + 1);

  code_entry_t       mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CountW-1:0] count_q;
  logic              push, pop;

  assign wr_ready_o = (count_q != CountW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (pop)  rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= wr_entry_i;
  end

endmodule

`default_nettype wire

// ----- sv/xfse_back.sv -----
`default_nettype none

module xfse_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       entry_valid_i,
  output logic                       entry_ready_o,
  input  xfse_pkg::code_entry_t      entry_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [xfse_pkg::ByteW-1:0] out_byte_o,
  output logic                       last_of_run_o,
  output logic                       stream_done_o
);
  import xfse_pkg::*;

  logic              busy_q, busy_d;
  logic              item_last_q, item_last_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              ov_q, ov_d;
  logic [ByteW-1:0]  byte_q, byte_d;
  logic              lor_q, lor_d;
  logic              sd_q, sd_d;

  always_comb begin
    logic            out_free;
    logic            emit;
    logic            fin;
    logic [CntW-1:0] rem;

    busy_d      = busy_q;
    item_last_d = item_last_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    ov_d        = ov_q;
    byte_d      = byte_q;
    lor_d       = lor_q;
    sd_d        = sd_q;
    out_free    = !ov_q || out_ready_i;
    emit        = 1'b0;
    fin         = 1'b0;
    rem         = cnt_q - CntW'(ByteW);

    entry_ready_o = !busy_q;

    if (busy_q) begin
      if (cnt_q >= CntW'(ByteW)) begin
        if (out_free) begin
          emit  = 1'b1;
          fin   = (rem < CntW'(ByteW)) && (!item_last_q || rem == '0);
          acc_d = acc_q << ByteW;
          cnt_d = rem;
          if (fin) begin
            busy_d = 1'b0;
            if (item_last_q) begin
              acc_d = '0;
              cnt_d = '0;
            end
          end
        end
      end else if (item_last_q) begin
        // Padded final byte: the bits below the count are already zero.
        if (out_free) begin
          emit   = 1'b1;
          fin    = 1'b1;
          busy_d = 1'b0;
          acc_d  = '0;
          cnt_d  = '0;
        end
      end else begin
        busy_d = 1'b0;
      end
    end else if (entry_valid_i) begin
      busy_d      = 1'b1;
      item_last_d = entry_i.last;
      acc_d       = acc_q | ({entry_i.code, {(AccW-CodeW){1'b0}}} >> cnt_q[2:0]);
      cnt_d       = cnt_q + entry_i.nbits;
    end

    if (out_free) begin
      ov_d = emit;
      if (emit) begin
        byte_d = acc_q[AccW-1 -: ByteW];
        lor_d  = fin;
        sd_d   = fin && item_last_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      item_last_q <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      ov_q        <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      item_last_q <= item_last_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    lor_q  <= lor_d;
    sd_q   <= sd_d;
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = lor_q;
  assign stream_done_o = sd_q;

endmodule

`default_nettype wire
